FILE: src/fir_filter_circular_assert.svh
// Assertion helpers for the file that checks the filter sequencer.
`ifndef FIR_FILTER_CIRCULAR_ASSERT_SVH
`define FIR_FILTER_CIRCULAR_ASSERT_SVH

// Same-cycle implication, sampled on clk and off while rst_n is low.
`define FIRC_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, sampled on clk and off while rst_n is low.
`define FIRC_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

FILE: src/firc_pkg.sv
package firc_pkg;

  localparam int unsigned TAPS_DEF     = 512;
  localparam int unsigned SAMPLE_W_DEF = 16;
  localparam int unsigned COEF_W_DEF   = 16;
  localparam int unsigned TAP_INDEX_W  = 9;

  typedef enum logic {
    CMD_LOAD   = 1'b0,
    CMD_SAMPLE = 1'b1
  } firc_cmd_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_RUN,
    S_DRAIN,
    S_ROUND,
    S_OUTPUT
  } firc_state_t;

  // Per-cycle command for every cell of the tap chain.
  typedef struct packed {
    logic shift_in;  // new sample enters cell 0, history moves one cell up
    logic rotate;    // every cell takes the pair of its upper neighbor
  } firc_cell_ctl_t;

endpackage

FILE: src/firc_cell.sv
module firc_cell #(
  parameter int unsigned SAMPLE_WIDTH = 16,
  parameter int unsigned COEF_WIDTH   = 16
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  firc_pkg::firc_cell_ctl_t    ctl,
  input  logic                        coef_we,
  input  logic [COEF_WIDTH-1:0]       coef_in,
  input  logic [SAMPLE_WIDTH-1:0]     samp_left,
  input  logic [SAMPLE_WIDTH-1:0]     samp_right,
  input  logic [COEF_WIDTH-1:0]       coef_right,
  output logic [SAMPLE_WIDTH-1:0]     samp,
  output logic [COEF_WIDTH-1:0]       coef
);

  logic [SAMPLE_WIDTH-1:0] samp_r, samp_nxt;
  logic [COEF_WIDTH-1:0]   coef_r, coef_nxt;

  always_comb begin
    samp_nxt = samp_r;
    coef_nxt = coef_r;
    if (ctl.rotate) begin
      samp_nxt = samp_right;
      coef_nxt = coef_right;
    end else if (ctl.shift_in) begin
      samp_nxt = samp_left;
    end
    if (coef_we) begin
      coef_nxt = coef_in;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      samp_r <= '0;
      coef_r <= '0;
    end else begin
      samp_r <= samp_nxt;
      coef_r <= coef_nxt;
    end
  end

  assign samp = samp_r;
  assign coef = coef_r;

endmodule

FILE: src/firc_mac.sv
module firc_mac #(
  parameter int unsigned TAPS         = 512,
  parameter int unsigned SAMPLE_WIDTH = 16,
  parameter int unsigned COEF_WIDTH   = 16
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           issue,
  input  logic                           acc_clr,
  input  logic                           round_en,
  input  logic signed [SAMPLE_WIDTH-1:0] samp,
  input  logic signed [COEF_WIDTH-1:0]   coef,
  output logic [SAMPLE_WIDTH-1:0]        result
);

  localparam int unsigned PROD_W = SAMPLE_WIDTH + COEF_WIDTH;
  localparam int unsigned FULL_W = PROD_W + $clog2(TAPS);
  // The sum wraps at 64 bits; below that it is wide enough never to wrap.
  localparam int unsigned ACC_W  = (FULL_W > 64) ? 64 : FULL_W;
  localparam int unsigned RND_W  = (ACC_W == 64) ? 64 : ACC_W + 1;
  localparam int unsigned SH_W   = RND_W - (COEF_WIDTH - 1);

  localparam logic [RND_W-1:0] HALF = RND_W'(1) << (COEF_WIDTH - 2);
  localparam logic signed [SH_W-1:0] SAT_HI =
    {{(SH_W - SAMPLE_WIDTH + 1){1'b0}}, {(SAMPLE_WIDTH - 1){1'b1}}};
  localparam logic signed [SH_W-1:0] SAT_LO =
    {{(SH_W - SAMPLE_WIDTH + 1){1'b1}}, {(SAMPLE_WIDTH - 1){1'b0}}};

  logic signed [PROD_W-1:0] prod_r, prod_nxt;
  logic                     pvld_r;
  logic signed [ACC_W-1:0]  acc_r, acc_nxt;
  logic signed [RND_W-1:0]  rnd_sum;
  logic signed [SH_W-1:0]   rnd_r, rnd_nxt;

  always_comb begin
    prod_nxt = samp * coef;
    acc_nxt  = acc_r;
    if (acc_clr) begin
      acc_nxt = '0;
    end else if (pvld_r) begin
      acc_nxt = acc_r + ACC_W'(prod_r);
    end
    rnd_sum = $signed(RND_W'(acc_r) + HALF);
    rnd_nxt = SH_W'(rnd_sum >>> (COEF_WIDTH - 1));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pvld_r <= 1'b0;
    end else begin
      pvld_r <= issue;
    end
  end

  always_ff @(posedge clk) begin
    if (issue) begin
      prod_r <= prod_nxt;
    end
    acc_r <= acc_nxt;
    if (round_en) begin
      rnd_r <= rnd_nxt;
    end
  end

  always_comb begin
    if (rnd_r > SAT_HI) begin
      result = SAT_HI[SAMPLE_WIDTH-1:0];
    end else if (rnd_r < SAT_LO) begin
      result = SAT_LO[SAMPLE_WIDTH-1:0];
    end else begin
      result = rnd_r[SAMPLE_WIDTH-1:0];
    end
  end

endmodule

FILE: src/fir_filter_circular.sv
// Direct-form FIR filter. A coefficient item (tuser low) writes one Q1.15 tap and
// leaves the block idle; a tap index at or beyond TAPS is dropped. A sample item
// (tuser high) enters the history and gives one rounded, saturated output after
// the run, drain, round and output steps; no new item is taken until the sample
// has passed them. This pace is set by the single multiplier: the history and
// coefficients sit in a chain of TAPS cells that rotates one place per cycle past
// it, one multiply-accumulate per tap. History and taps reset to zero directly,
// with no clearing pass. A finished output waits in its register while the next
// item is taken; the output step holds until that register is free or being read.
`include "fir_filter_circular_assert.svh"

module fir_filter_circular #(
  parameter int unsigned TAPS         = firc_pkg::TAPS_DEF,
  parameter int unsigned SAMPLE_WIDTH = firc_pkg::SAMPLE_W_DEF,
  parameter int unsigned COEF_WIDTH   = firc_pkg::COEF_W_DEF
) (
  input  logic clk,
  input  logic rst_n,
  input  logic in_tvalid,
  output logic in_tready,
  // sample_in, tap_index (9 bits), tap_value, zero fill
  input  logic [((SAMPLE_WIDTH + firc_pkg::TAP_INDEX_W + COEF_WIDTH + 7) / 8) * 8 - 1:0]
               in_tdata,
  input  logic in_tuser,  // cmd
  output logic out_tvalid,
  input  logic out_tready,
  // filtered, zero fill
  output logic [((SAMPLE_WIDTH + 7) / 8) * 8 - 1:0] out_tdata
);

  import firc_pkg::*;

  localparam int unsigned OUT_W = ((SAMPLE_WIDTH + 7) / 8) * 8;
  localparam int unsigned CNT_W = $clog2(TAPS);
  localparam int unsigned IDX_LO = SAMPLE_WIDTH;
  localparam int unsigned VAL_LO = SAMPLE_WIDTH + TAP_INDEX_W;

  firc_state_t state_r, state_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic out_tvalid_r, out_tvalid_nxt;
  logic [SAMPLE_WIDTH-1:0] out_data_r;

  logic in_fire, out_fire, load_fire, samp_fire, out_load;
  firc_cell_ctl_t cell_ctl;

  logic [SAMPLE_WIDTH-1:0] in_sample;
  logic [TAP_INDEX_W-1:0]  in_idx;
  logic [COEF_WIDTH-1:0]   in_coef;
  logic [SAMPLE_WIDTH-1:0] mac_result;

  logic [SAMPLE_WIDTH-1:0] samp_w [TAPS];
  logic [COEF_WIDTH-1:0]   coef_w [TAPS];
  logic [SAMPLE_WIDTH-1:0] left_w [TAPS];

  assign in_sample = in_tdata[SAMPLE_WIDTH-1:0];
  assign in_idx    = in_tdata[IDX_LO +: TAP_INDEX_W];
  assign in_coef   = in_tdata[VAL_LO +: COEF_WIDTH];

  assign in_tready = (state_r == S_IDLE);
  assign in_fire   = in_tvalid && in_tready;
  assign samp_fire = in_fire && (in_tuser == CMD_SAMPLE);
  assign load_fire = in_fire && (in_tuser == CMD_LOAD);
  assign out_fire  = out_tvalid_r && out_tready;
  assign out_load  = (state_r == S_OUTPUT) && (!out_tvalid_r || out_tready);

  // Next state.
  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    unique case (state_r)
      S_IDLE: begin
        cnt_nxt = '0;
        if (samp_fire) begin
          state_nxt = S_RUN;
        end
      end
      S_RUN: begin
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_r == CNT_W'(TAPS - 1)) begin
          state_nxt = S_DRAIN;
        end
      end
      S_DRAIN:  state_nxt = S_ROUND;
      S_ROUND:  state_nxt = S_OUTPUT;
      S_OUTPUT: begin
        if (out_load) begin
          state_nxt = S_IDLE;
        end
      end
      default:  state_nxt = S_IDLE;
    endcase
  end

  // Outputs of the sequencer.
  always_comb begin
    cell_ctl.shift_in = samp_fire;
    cell_ctl.rotate   = (state_r == S_RUN);
    out_tvalid_nxt    = out_tvalid_r;
    if (out_fire) begin
      out_tvalid_nxt = 1'b0;
    end
    if (out_load) begin
      out_tvalid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      cnt_r        <= '0;
      out_tvalid_r <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      cnt_r        <= cnt_nxt;
      out_tvalid_r <= out_tvalid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_data_r <= mac_result;
    end
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = OUT_W'(out_data_r);

  // Cell i holds coefficient i and the sample i steps back. While running,
  // the chain rotates so that cell 0 presents each pair once.
  for (genvar i = 0; i < TAPS; i++) begin : g_cell
    localparam int unsigned Right = (i + 1) % TAPS;
    logic we;

    if (i == 0) begin : g_head
      assign left_w[i] = in_sample;
    end else begin : g_body
      assign left_w[i] = samp_w[i-1];
    end

    assign we = load_fire && (32'(in_idx) == i);

    firc_cell #(
      .SAMPLE_WIDTH (SAMPLE_WIDTH),
      .COEF_WIDTH   (COEF_WIDTH)
    ) u_cell (
      .clk        (clk),
      .rst_n      (rst_n),
      .ctl        (cell_ctl),
      .coef_we    (we),
      .coef_in    (in_coef),
      .samp_left  (left_w[i]),
      .samp_right (samp_w[Right]),
      .coef_right (coef_w[Right]),
      .samp       (samp_w[i]),
      .coef       (coef_w[i])
    );
  end

  firc_mac #(
    .TAPS         (TAPS),
    .SAMPLE_WIDTH (SAMPLE_WIDTH),
    .COEF_WIDTH   (COEF_WIDTH)
  ) u_mac (
    .clk      (clk),
    .rst_n    (rst_n),
    .issue    (state_r == S_RUN),
    .acc_clr  (samp_fire),
    .round_en (state_r == S_ROUND),
    .samp     ($signed(samp_w[0])),
    .coef     ($signed(coef_w[0])),
    .result   (mac_result)
  );

  `FIRC_ASSERT_NEXT(a_sample_starts_run, samp_fire, (state_r == S_RUN) && (cnt_r == '0), "sample item did not start the tap sweep")
  `FIRC_ASSERT_NEXT(a_run_ends, (state_r == S_RUN) && (cnt_r == CNT_W'(TAPS - 1)), state_r == S_DRAIN, "tap sweep did not end after TAPS cycles")
  `FIRC_ASSERT_SAME(a_out_from_seq, $rose(out_tvalid_r), $past(state_r) == S_OUTPUT, "output item raised outside the output step")

endmodule

FILE: sim/tb_fir_filter_circular.sv
module tb_fir_filter_circular;
  timeunit 1ns;
  timeprecision 1ps;

  import firc_pkg::*;

  localparam int unsigned TAPS   = TAPS_DEF;
  localparam int unsigned SW     = SAMPLE_W_DEF;
  localparam int unsigned CW     = COEF_W_DEF;
  localparam int unsigned IW     = TAP_INDEX_W;
  localparam int unsigned DATA_W = ((SW + IW + CW + 7) / 8) * 8;
  localparam int unsigned OUT_W  = ((SW + 7) / 8) * 8;

  localparam longint OUT_MAX = (longint'(1) << (SW - 1)) - 1;
  localparam longint OUT_MIN = -OUT_MAX - 1;

  // Cycles that one sample occupies the block while the output is not held.
  localparam int unsigned SAMPLE_CYCLES = TAPS + 4;
  localparam int unsigned LONG_HOLD     = 4000;
  localparam longint      CYCLE_LIMIT   = 5_000_000;

  logic              clk        = 1'b0;
  logic              rst_n      = 1'b0;
  logic              in_tvalid  = 1'b0;
  logic              in_tready;
  logic [DATA_W-1:0] in_tdata   = '0;  // sample_in, tap_index, tap_value, zero fill
  logic              in_tuser   = 1'b0;  // cmd
  logic              out_tvalid;
  logic              out_tready = 1'b0;
  logic [OUT_W-1:0]  out_tdata;  // filtered, zero fill

  // Predictor state.
  logic signed [CW-1:0] tap_coefs   [TAPS];
  logic signed [SW-1:0] sample_ring [TAPS];
  int unsigned          ring_pos;
  logic signed [SW-1:0] pending_outputs [$];

  int     errors        = 0;
  longint cycle_count   = 0;
  int     send_idle_pct = 0;
  int     recv_stall_pct = 0;
  int     hold_request  = 0;
  int     hold_seen     = 0;
  int     hold_left     = 0;

  fir_filter_circular DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  always #2 clk = ~clk;

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("%0t: timeout after %0d cycles", $time, cycle_count);
      $display("Regression FAIL");
      $finish;
    end
  end

  function automatic logic signed [SW-1:0] filter_output(int unsigned newest);
    longint      acc;
    longint      y;
    int unsigned idx;
    acc = 0;
    for (int unsigned k = 0; k < TAPS; k++) begin
      idx = (newest + TAPS - k) % TAPS;
      acc += longint'(tap_coefs[k]) * longint'(sample_ring[idx]);
    end
    y = (acc + (longint'(1) << (CW - 2))) >>> (CW - 1);
    if (y > OUT_MAX) y = OUT_MAX;
    if (y < OUT_MIN) y = OUT_MIN;
    return y[SW-1:0];
  endfunction

  task automatic predict_item(firc_cmd_t cmd, logic [SW-1:0] smp, logic [IW-1:0] idx,
                              logic [CW-1:0] coef);
    if (cmd == CMD_LOAD) begin
      if (idx < TAPS) tap_coefs[idx] = coef;
    end else begin
      sample_ring[ring_pos] = smp;
      pending_outputs.push_back(filter_output(ring_pos));
      ring_pos = (ring_pos + 1) % TAPS;
    end
  endtask

  // Called at a rising edge; drives at a falling edge, after an optional idle gap, and returns at acceptance.
  task automatic send_item(firc_cmd_t cmd, logic [SW-1:0] smp, logic [IW-1:0] idx,
                           logic [CW-1:0] coef);
    logic [DATA_W-1:0] word;
    int                gap;
    word = '0;
    word[SW-1:0] = smp;
    word[SW +: IW] = idx;
    word[SW + IW +: CW] = coef;
    @(negedge clk);
    if ($urandom_range(99) < send_idle_pct) begin
      // Mostly short gaps, now and then one that may span a whole sample computation.
      gap = ($urandom_range(19) == 0) ? $urandom_range(SAMPLE_CYCLES + 8, 1)
                                      : $urandom_range(3, 1);
      in_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= word;
    in_tuser  <= cmd;
    do @(posedge clk); while (!in_tready);
    predict_item(cmd, smp, idx, coef);
  endtask

  always @(negedge clk) begin
    if (hold_request != hold_seen) begin
      hold_seen = hold_request;
      hold_left = LONG_HOLD;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_tready <= 1'b0;
    end else begin
      out_tready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  always @(posedge clk) begin
    logic signed [SW-1:0] want;
    if (rst_n && out_tvalid && out_tready) begin
      if (pending_outputs.size() == 0) begin
        $display("%0t: output with none expected, expected none, got %0d", $time,
                 $signed(out_tdata[SW-1:0]));
        errors++;
      end else begin
        want = pending_outputs.pop_front();
        if (out_tdata !== OUT_W'($unsigned(want))) begin
          $display("%0t: filtered mismatch, expected %0d, got %0d (raw %h)", $time,
                   want, $signed(out_tdata[SW-1:0]), out_tdata);
          errors++;
        end
      end
    end
  end

  function automatic logic [15:0] rand_q15();
    logic [31:0]        r;
    logic signed [15:0] v;
    int                 sh;
    r  = $urandom;
    sh = $urandom_range(15);
    v  = r[15:0];
    return v >>> sh;
  endfunction

  task automatic set_idling(int send_pct, int recv_pct);
    send_idle_pct  = send_pct;
    recv_stall_pct = recv_pct;
  endtask

  // Table extremes, rounding at one half, and saturation in both directions.
  task automatic test_directed();
    set_idling(0, 0);
    send_item(CMD_SAMPLE, 16'h7fff, 9'h1ff, 16'h7fff);  // empty table gives zero
    send_item(CMD_LOAD,   16'h8000, 9'd0,   16'h4000);  // tap 0 = one half
    send_item(CMD_SAMPLE, 16'h0001, 9'h0aa, 16'h5555);  // rounds up to 1
    send_item(CMD_SAMPLE, 16'hffff, 9'h155, 16'haaaa);  // rounds to 0
    send_item(CMD_LOAD,   16'h7fff, 9'd0,   16'h8000);
    send_item(CMD_LOAD,   16'h0000, 9'd1,   16'h8000);
    send_item(CMD_SAMPLE, 16'h8000, 9'd0,   16'h0000);
    send_item(CMD_SAMPLE, 16'h8000, 9'd0,   16'h0000);  // saturates high
    send_item(CMD_SAMPLE, 16'h7fff, 9'd0,   16'h0000);
    send_item(CMD_SAMPLE, 16'h7fff, 9'd0,   16'h0000);  // saturates low
    send_item(CMD_LOAD,   16'hffff, 9'h1ff, 16'h7fff);  // last tap
    send_item(CMD_LOAD,   16'h5555, 9'h155, 16'hffff);
    send_item(CMD_LOAD,   16'haaaa, 9'h0aa, 16'h0001);
    send_item(CMD_SAMPLE, 16'h0000, 9'h1ff, 16'hffff);
    send_item(CMD_SAMPLE, 16'h5555, 9'h000, 16'h0000);
    send_item(CMD_SAMPLE, 16'haaaa, 9'h1ff, 16'hffff);
    send_item(CMD_LOAD,   16'h0000, 9'd0,   16'h0000);
    send_item(CMD_LOAD,   16'h0000, 9'd1,   16'h0000);
    send_item(CMD_SAMPLE, 16'h8000, 9'd0,   16'h0000);
    send_item(CMD_SAMPLE, 16'h7fff, 9'd0,   16'h0000);
  endtask

  // The receiver holds off long enough that finished outputs back up into the input.
  task automatic test_backpressure();
    set_idling(0, 0);
    hold_request++;
    repeat (8) send_item(CMD_SAMPLE, rand_q15(), 9'($urandom_range(TAPS - 1)), rand_q15());
  endtask

  task automatic test_random_traffic(int count, int send_pct, int recv_pct);
    firc_cmd_t     cmd;
    logic [CW-1:0] coef;
    set_idling(send_pct, recv_pct);
    repeat (count) begin
      cmd  = ($urandom_range(99) < 45) ? CMD_LOAD : CMD_SAMPLE;
      // Some zero writes keep the table partly sparse so outputs do not all saturate.
      coef = ($urandom_range(4) == 0) ? '0 : rand_q15();
      send_item(cmd, rand_q15(), 9'($urandom_range(TAPS - 1)), coef);
    end
  endtask

  task automatic finish_run();
    @(negedge clk);
    in_tvalid <= 1'b0;
    while (pending_outputs.size() != 0) @(posedge clk);
    repeat (SAMPLE_CYCLES + 16) @(posedge clk);
    if (errors == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  endtask

  initial begin
    for (int i = 0; i < TAPS; i++) begin
      tap_coefs[i]   = '0;
      sample_ring[i] = '0;
    end
    ring_pos = 0;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_directed();
    test_backpressure();
    test_random_traffic(285, 0, 0);
    test_random_traffic(285, 53, 0);
    test_random_traffic(285, 0, 53);
    test_random_traffic(285, 17, 17);
    finish_run();
  end

endmodule
